[rtl/lgs_pkg.sv]
// lgs_pkg: shared types, codes and constants of the life grid step unit.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package lgs_pkg;

   // Grid size limits (defaults for the top level parameters)
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 32;

   // Payload field widths
   localparam int OP_W     = 2;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 6;
   localparam int GRID_W_W = 7;
   localparam int GRID_H_W = 6;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = GRID_W_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 1'd1;

   localparam logic [GRID_W_W-1:0] GRID_WIDTH_RESET  = 7'd60;
   localparam logic [GRID_H_W-1:0] GRID_HEIGHT_RESET = 6'd30;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

   // B3/S23 rule
   localparam int NBR_CNT_W = 4;
   localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CELL,
      S_ADV,
      S_DRAIN,
      S_DONE
   } state_type;

   // How an incoming transaction is handled
   typedef enum logic [1:0] {
      K_DIRECT,   // result known at accept
      K_CELL,     // one row read, optional write-back
      K_ADV       // full grid sweep
   } kind_type;

   typedef struct packed {
      logic accept;
      logic adv_step;
      logic cell_finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     adv_last;
      logic     out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/lgs_channels.sv]
// lgs_req_if / lgs_rsp_if: valid/ready channel interfaces of the life grid step unit.
// Depends on lgs_pkg for the field widths.
`default_nettype none

interface lgs_req_if;
   import lgs_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [ROW_W-1:0] row_index;
   logic [COL_W-1:0] column_index;
   logic             write_alive;

   modport source (output valid, operation, row_index, column_index, write_alive,
                   input ready);
   modport sink   (input valid, operation, row_index, column_index, write_alive,
                   output ready);
endinterface

interface lgs_rsp_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic live_before;
   logic out_of_range;

   modport source (output valid, cell_alive, live_before, out_of_range, input ready);
   modport sink   (input valid, cell_alive, live_before, out_of_range, output ready);
endinterface

`default_nettype wire

[rtl/lgs_ram.sv]
// lgs_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on lgs_pkg for default sizes only.
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = lgs_pkg::MAX_WIDTH_DEF,
   parameter int DEPTH = lgs_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/lgs_ctrl.sv]
// lgs_ctrl: transaction sequencer of the life grid step unit.
// Depends on lgs_pkg (state, command and status types).
`default_nettype none

module lgs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lgs_pkg::status_type status,
   output lgs_pkg::cmd_type         cmd
);
   import lgs_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (status.kind)
                  K_CELL:  state_in = S_CELL;
                  K_ADV:   state_in = S_ADV;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CELL: begin
            cmd.cell_finish = 1'b1;
            state_in        = S_DONE;
         end
         S_ADV: begin
            // one row read per cycle; the last step is past the bottom row and reads nothing
            cmd.adv_step = 1'b1;
            if (status.adv_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result is never pushed over one that has not been taken
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded while output register still full");

   // Every accepted transaction takes the controller out of S_IDLE
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("controller idle right after an accept");

endmodule

`default_nettype wire

[rtl/lgs_datapath.sv]
// lgs_datapath: grid row memory, B3/S23 row update lanes, config and result registers.
// Depends on lgs_pkg and lgs_ram.
`default_nettype none

module lgs_datapath #(
   parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lgs_pkg::cmd_type                  cmd,
   output lgs_pkg::status_type                    status,
   input  wire logic [lgs_pkg::OP_W-1:0]          req_operation,
   input  wire logic [lgs_pkg::ROW_W-1:0]         req_row_index,
   input  wire logic [lgs_pkg::COL_W-1:0]         req_column_index,
   input  wire logic                              req_write_alive,
   input  wire logic                              csr_write_enable,
   input  wire logic [lgs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lgs_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_cell_alive,
   output logic                                   rsp_live_before,
   output logic                                   rsp_out_of_range
);
   import lgs_pkg::*;

   localparam int WCW = $clog2(MAX_WIDTH + 1);   // holds 0..MAX_WIDTH
   localparam int HCW = $clog2(MAX_HEIGHT + 1);  // holds 0..MAX_HEIGHT
   localparam int RAW = $clog2(MAX_HEIGHT);      // row address
   localparam int CIW = $clog2(MAX_WIDTH);       // column index

   // Configuration registers
   logic [GRID_W_W-1:0] grid_width_ff;
   logic [GRID_H_W-1:0] grid_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_write_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_write_data[GRID_H_W-1:0];
            default: ;
         endcase
      end
   end

   // Size in use, clipped to the storage limits
   logic [WCW-1:0]       w_eff;
   logic [HCW-1:0]       h_eff;
   logic [MAX_WIDTH-1:0] col_mask;

   always_comb begin
      if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(grid_width_ff);
      end
      if (32'(grid_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HCW'(MAX_HEIGHT);
      end else begin
         h_eff = HCW'(grid_height_ff);
      end
      for (int c = 0; c < MAX_WIDTH; c++) begin
         col_mask[c] = (c < int'(w_eff));
      end
   end

   // Request decode
   logic           req_row_ok;
   logic           req_col_ok;
   logic           req_is_cell;
   logic           req_oor;
   logic [RAW-1:0] req_row_addr;
   kind_type       req_kind;

   always_comb begin
      req_row_ok   = 32'(req_row_index) < 32'(h_eff);
      req_col_ok   = 32'(req_column_index) < 32'(w_eff);
      req_is_cell  = (req_operation == OP_WRITE) || (req_operation == OP_READ);
      req_oor      = req_is_cell && !(req_row_ok && req_col_ok);
      req_row_addr = RAW'(req_row_index);
      case (req_operation)
         OP_WRITE, OP_READ: req_kind = req_oor ? K_DIRECT : K_CELL;
         OP_ADVANCE:        req_kind = (w_eff == '0 || h_eff == '0) ? K_DIRECT : K_ADV;
         default:           req_kind = K_DIRECT;
      endcase
   end

   // Row storage; a row not yet written since reset reads as all dead
   logic [MAX_HEIGHT-1:0] row_valid_ff;
   logic                  ram_we;
   logic [RAW-1:0]        ram_waddr;
   logic [MAX_WIDTH-1:0]  ram_wdata;
   logic                  ram_re;
   logic [RAW-1:0]        ram_raddr;
   logic [MAX_WIDTH-1:0]  ram_rdata;

   lgs_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ram_we) begin
         row_valid_ff[ram_waddr] <= 1'b1;
      end
   end

   // Latched cell transaction
   logic [OP_W-1:0] op_ff;
   logic [RAW-1:0]  row_ff;
   logic [CIW-1:0]  col_ff;
   logic            wval_ff;
   logic            cell_vld_ff;

   // Advance sweep state
   logic [HCW-1:0]       rd_row_ff;
   logic                 rd_row_lt;
   logic                 pend_ff;
   logic [HCW-1:0]       pend_row_ff;
   logic                 pend_beyond_ff;
   logic                 pend_vld_ff;
   logic [MAX_WIDTH-1:0] above_ff;
   logic [MAX_WIDTH-1:0] cur_ff;
   logic [MAX_WIDTH-1:0] cur_raw_ff;

   // Result registers
   logic res_cell_ff;
   logic res_any_ff;
   logic res_oor_ff;

   assign rd_row_lt = rd_row_ff < h_eff;

   // Incoming row of the sweep, bottom neighbor of the row being updated
   logic [MAX_WIDTH-1:0] raw_row;
   logic [MAX_WIDTH-1:0] below_row;
   logic [MAX_WIDTH-1:0] next_row;

   assign raw_row   = pend_vld_ff ? ram_rdata : '0;
   assign below_row = pend_beyond_ff ? '0 : (raw_row & col_mask);

   // B3/S23 update lanes, one per column
   always_comb begin
      logic [MAX_WIDTH+1:0] a_ext;
      logic [MAX_WIDTH+1:0] c_ext;
      logic [MAX_WIDTH+1:0] b_ext;
      logic [NBR_CNT_W-1:0] n;
      a_ext = {1'b0, above_ff, 1'b0};
      c_ext = {1'b0, cur_ff, 1'b0};
      b_ext = {1'b0, below_row, 1'b0};
      for (int c = 0; c < MAX_WIDTH; c++) begin
         n = NBR_CNT_W'(a_ext[c]) + NBR_CNT_W'(a_ext[c+1]) + NBR_CNT_W'(a_ext[c+2])
           + NBR_CNT_W'(c_ext[c]) + NBR_CNT_W'(c_ext[c+2])
           + NBR_CNT_W'(b_ext[c]) + NBR_CNT_W'(b_ext[c+1]) + NBR_CNT_W'(b_ext[c+2]);
         next_row[c] = col_mask[c]
                     && ((n == BIRTH_COUNT) || (cur_ff[c] && (n == SURVIVE_COUNT)));
      end
   end

   // Row write-back of the sweep and of a cell write
   logic                 adv_we;
   logic [HCW-1:0]       adv_wrow;
   logic                 cell_we;
   logic [MAX_WIDTH-1:0] cell_row;
   logic [MAX_WIDTH-1:0] cell_wdata;

   always_comb begin
      adv_we     = pend_ff && (pend_row_ff != '0);
      adv_wrow   = pend_row_ff - HCW'(1);
      cell_row   = cell_vld_ff ? ram_rdata : '0;
      cell_we    = cmd.cell_finish && (op_ff == OP_WRITE);
      cell_wdata = cell_row;
      cell_wdata[col_ff] = wval_ff;
      ram_we    = adv_we || cell_we;
      ram_waddr = cell_we ? row_ff : RAW'(adv_wrow);
      ram_wdata = cell_we ? cell_wdata : ((cur_raw_ff & ~col_mask) | next_row);
      ram_re    = (cmd.accept && (req_kind == K_CELL)) || (cmd.adv_step && rd_row_lt);
      ram_raddr = cmd.accept ? req_row_addr : RAW'(rd_row_ff);
   end

   // Transaction latch, sweep control and results
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.adv_step;
      end

      // cur_ff is cleared to stand for the empty row above row 0; it moves to above_ff at the first window shift
      if (cmd.accept) begin
         op_ff       <= req_operation;
         row_ff      <= req_row_addr;
         col_ff      <= CIW'(req_column_index);
         wval_ff     <= req_write_alive;
         cell_vld_ff <= req_row_ok && row_valid_ff[req_row_addr];
         res_cell_ff <= 1'b0;
         res_any_ff  <= 1'b0;
         res_oor_ff  <= req_oor;
         rd_row_ff   <= '0;
         cur_ff      <= '0;
      end

      if (cmd.adv_step) begin
         pend_row_ff    <= rd_row_ff;
         pend_beyond_ff <= !rd_row_lt;
         pend_vld_ff    <= rd_row_lt && row_valid_ff[RAW'(rd_row_ff)];
         rd_row_ff      <= rd_row_ff + HCW'(1);
      end

      // shift the three-row window down by one
      if (pend_ff) begin
         above_ff   <= cur_ff;
         cur_ff     <= below_row;
         cur_raw_ff <= raw_row;
         if (|below_row) begin
            res_any_ff <= 1'b1;
         end
      end

      if (cmd.cell_finish) begin
         res_cell_ff <= (op_ff == OP_READ) && cell_row[col_ff];
      end
   end

   // Output register
   logic out_valid_ff;
   logic out_cell_ff;
   logic out_any_ff;
   logic out_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_cell_ff <= res_cell_ff;
         out_any_ff  <= res_any_ff;
         out_oor_ff  <= res_oor_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cell_alive   = out_cell_ff;
   assign rsp_live_before  = out_any_ff;
   assign rsp_out_of_range = out_oor_ff;

   // Status to the controller
   always_comb begin
      status.kind     = req_kind;
      status.adv_last = (rd_row_ff == h_eff);
      status.out_free = !out_valid_ff || rsp_ready;
   end

   // Sweep write-back and cell write-back never collide on the write port
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(adv_we && cell_we))
      else $error("sweep and cell write in the same cycle");

   // The sweep writes only rows inside the grid in use
   a_sweep_in_grid: assert property (@(posedge clock) disable iff (reset)
      adv_we |-> (adv_wrow < h_eff))
      else $error("sweep wrote a row outside the grid in use");

endmodule

`default_nettype wire

[rtl/life_automaton_grid_step_unit.sv]
// life_automaton_grid_step_unit: top level of the bounded B3/S23 life grid.
// Depends on lgs_pkg, lgs_channels, lgs_ctrl, lgs_datapath (and lgs_ram below it).
//
//   channel    direction  handshake            payload
//   req_chan   in         valid/ready          operation, row_index, column_index,
//                                              write_alive
//   rsp_chan   out        valid/ready          cell_alive, live_before, out_of_range
//   csr_*      in         write enable only    csr_index, csr_write_data
//
// Cell read/write: accept with row read, then row write-back for a write, then result load.
// Advance: one row word per cycle through the single read port of the row RAM;
// zero-size grids and bad indexes go from accept straight to the result load.
// Reset clears the grid at once through per-row valid bits and sets 60 x 30.
// A result waits in the output register; the next transaction is accepted and
// runs, and only its result load waits for the output register to empty.
`default_nettype none

module life_automaton_grid_step_unit #(
   parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lgs_req_if.sink                              req_chan,
   lgs_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [lgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lgs_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import lgs_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_cell_alive;
   logic       rsp_live_before;
   logic       rsp_out_of_range;

   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lgs_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_chan.operation),
      .req_row_index    (req_chan.row_index),
      .req_column_index (req_chan.column_index),
      .req_write_alive  (req_chan.write_alive),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_cell_alive   (rsp_cell_alive),
      .rsp_live_before  (rsp_live_before),
      .rsp_out_of_range (rsp_out_of_range)
   );

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.cell_alive   = rsp_cell_alive;
   assign rsp_chan.live_before  = rsp_live_before;
   assign rsp_chan.out_of_range = rsp_out_of_range;

endmodule

`default_nettype wire
